FILE: design/xor_float_window_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// XOR float window encoder assertion macros
// Shared concurrent assertion forms, compiled out under synthesis.
// ----------------------------------------------------------------------------
`ifndef XOR_FLOAT_WINDOW_ENCODER_TOP_DEFINES_SVH
`define XOR_FLOAT_WINDOW_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define XFWE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xfwe same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define XFWE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xfwe next-cycle check failed");
`else
`define XFWE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define XFWE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/xfwe_pkg.sv
// ----------------------------------------------------------------------------
// XOR float window encoder package
// Types, codes and constants shared by the encoder modules.
// ----------------------------------------------------------------------------
package xfwe_pkg;

   localparam int VALUE_BITS = 64;

   // Leading-zero counts at or above the limit are coded as the clamp value.
   localparam logic [5:0] LEAD_LIMIT = 6'd32;
   localparam logic [4:0] LEAD_CLAMP = 5'd31;

   // Header codes and lengths.
   localparam logic [12:0] HDR_REPEAT  = 13'd0;
   localparam logic [12:0] HDR_REUSE   = 13'd2;
   localparam logic [1:0]  HDR_NEW_CTL = 2'b11;
   localparam logic [3:0]  HDR_LEN_RAW    = 4'd0;
   localparam logic [3:0]  HDR_LEN_REPEAT = 4'd1;
   localparam logic [3:0]  HDR_LEN_REUSE  = 4'd2;
   localparam logic [3:0]  HDR_LEN_NEW    = 4'd13;
   localparam logic [6:0]  PAYLOAD_LEN_FULL = 7'd64;

   typedef enum logic [1:0] {
      KIND_RAW    = 2'd0,
      KIND_REPEAT = 2'd1,
      KIND_REUSE  = 2'd2,
      KIND_NEW    = 2'd3
   } kind_type;

   // Encoder history presented to the datapath.
   typedef struct packed {
      logic        awaiting_first;
      logic        no_window;
      logic [4:0]  window_lead;
      logic [6:0]  window_len;
      logic [63:0] previous_value;
   } history_type;

   // One encoded result.
   typedef struct packed {
      kind_type    kind;
      logic [12:0] header_bits;
      logic [3:0]  header_len;
      logic [63:0] payload;
      logic [6:0]  payload_len;
   } result_type;

endpackage

FILE: design/xfwe_zero_count.sv
// ----------------------------------------------------------------------------
// XOR float window encoder zero counter
// Leading and trailing zero counts of a nonzero 64-bit word.
// ----------------------------------------------------------------------------
module xfwe_zero_count (
   input  logic [63:0] word,
   output logic [5:0]  lead_zeros,
   output logic [5:0]  trail_zeros
);

   // Priority encoders: highest set bit gives the leading count, lowest the trailing.
   always_comb begin
      lead_zeros  = 6'd0;
      trail_zeros = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (word[i]) begin
            lead_zeros = 6'(63 - i);
         end
      end
      for (int j = 63; j >= 0; j--) begin
         if (word[j]) begin
            trail_zeros = 6'(j);
         end
      end
   end

endmodule

FILE: design/xfwe_encode.sv
// ----------------------------------------------------------------------------
// XOR float window encoder datapath
// Encodes one value against the stored history in a single pass.
// ----------------------------------------------------------------------------
module xfwe_encode (
   input  logic [63:0]          value_bits,
   input  xfwe_pkg::history_type hist,
   output xfwe_pkg::result_type  result
);

   logic [63:0] xor_word;
   logic [5:0]  lead_raw;
   logic [5:0]  trail;
   logic [4:0]  lead;
   logic [6:0]  len;
   logic [7:0]  new_end;
   logic [7:0]  window_end;
   logic        fits;
   logic [6:0]  reuse_shift;
   logic [63:0] reuse_mask;
   logic [63:0] new_mask;

   assign xor_word = value_bits ^ hist.previous_value;

   xfwe_zero_count u_zero_count (
      .word        (xor_word),
      .lead_zeros  (lead_raw),
      .trail_zeros (trail)
   );

   // Clamp the leading count and derive the meaningful length (1 to 64).
   assign lead = (lead_raw >= xfwe_pkg::LEAD_LIMIT) ? xfwe_pkg::LEAD_CLAMP : lead_raw[4:0];
   assign len  = 7'd64 - {2'b00, lead} - {1'b0, trail};

   // The new XOR fits if it starts no higher and ends no lower than the window.
   assign new_end    = {3'b000, lead} + {1'b0, len};
   assign window_end = {3'b000, hist.window_lead} + {1'b0, hist.window_len};
   assign fits = !hist.no_window && (lead >= hist.window_lead) && (new_end <= window_end);

   // Masks; a shift by 64 clears the word so a full length gives all ones.
   assign reuse_shift = 7'd64 - {2'b00, hist.window_lead} - hist.window_len;
   assign reuse_mask  = ~({64{1'b1}} << hist.window_len);
   assign new_mask    = ~({64{1'b1}} << len);

   // Select the coding for this value.
   always_comb begin
      if (hist.awaiting_first) begin
         result.kind        = xfwe_pkg::KIND_RAW;
         result.header_bits = xfwe_pkg::HDR_REPEAT;
         result.header_len  = xfwe_pkg::HDR_LEN_RAW;
         result.payload     = value_bits;
         result.payload_len = xfwe_pkg::PAYLOAD_LEN_FULL;
      end else if (xor_word == 64'd0) begin
         result.kind        = xfwe_pkg::KIND_REPEAT;
         result.header_bits = xfwe_pkg::HDR_REPEAT;
         result.header_len  = xfwe_pkg::HDR_LEN_REPEAT;
         result.payload     = 64'd0;
         result.payload_len = 7'd0;
      end else if (fits) begin
         result.kind        = xfwe_pkg::KIND_REUSE;
         result.header_bits = xfwe_pkg::HDR_REUSE;
         result.header_len  = xfwe_pkg::HDR_LEN_REUSE;
         result.payload     = (xor_word >> reuse_shift[5:0]) & reuse_mask;
         result.payload_len = hist.window_len;
      end else begin
         // A full-width window drops to zero in the six-bit length field.
         result.kind        = xfwe_pkg::KIND_NEW;
         result.header_bits = {xfwe_pkg::HDR_NEW_CTL, lead, len[5:0]};
         result.header_len  = xfwe_pkg::HDR_LEN_NEW;
         result.payload     = (xor_word >> trail) & new_mask;
         result.payload_len = len;
      end
   end

endmodule

FILE: design/xor_float_window_encoder_top.sv
// An accepted value passes through the input register and then the result register.
// Throughput: one value per cycle unless stalled; history updates in the single encode pass.
// Backpressure on the result side stalls both registers, so no result is dropped.
// Reset (synchronous, active high) empties both registers and restores the history:
// the next value is sent raw and no window is stored.
// ----------------------------------------------------------------------------
// XOR float window encoder top level
// Input register, single-pass XOR window encode and result register.
// ----------------------------------------------------------------------------
`include "xor_float_window_encoder_top_defines.svh"

module xor_float_window_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [12:0] rsp_header_bits,
   output logic [3:0]  rsp_header_len,
   output logic [63:0] rsp_payload,
   output logic [6:0]  rsp_payload_len
);

   logic                  in_valid_ff;
   logic [63:0]           in_value_ff;
   logic                  out_valid_ff;
   xfwe_pkg::result_type  out_result_ff;
   xfwe_pkg::history_type hist_ff;
   xfwe_pkg::history_type hist_in;
   xfwe_pkg::result_type  result;
   logic                  advance;

   // A value moves on when the result register is empty or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   xfwe_encode u_encode (
      .value_bits (in_value_ff),
      .hist       (hist_ff),
      .result     (result)
   );

   // History update for the value being encoded.
   always_comb begin
      hist_in = hist_ff;
      if (advance) begin
         hist_in.awaiting_first = 1'b0;
         if (result.kind != xfwe_pkg::KIND_REPEAT) begin
            hist_in.previous_value = in_value_ff;
         end
         if (result.kind == xfwe_pkg::KIND_NEW) begin
            hist_in.no_window   = 1'b0;
            hist_in.window_lead = result.header_bits[10:6];
            hist_in.window_len  = result.payload_len;
         end
      end
   end

   // Input register, result register and history.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                 <= 1'b0;
         out_valid_ff                <= 1'b0;
         hist_ff.awaiting_first      <= 1'b1;
         hist_ff.no_window           <= 1'b1;
         hist_ff.window_lead         <= 5'd0;
         hist_ff.window_len          <= 7'd0;
         hist_ff.previous_value      <= 64'd0;
      end else begin
         hist_ff <= hist_in;
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_value_ff <= req_value_bits;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_result_ff.kind;
   assign rsp_header_bits = out_result_ff.header_bits;
   assign rsp_header_len  = out_result_ff.header_len;
   assign rsp_payload     = out_result_ff.payload;
   assign rsp_payload_len = out_result_ff.payload_len;

   // Assertions.
   `XFWE_ASSERT_NEXT(a_advance_fills_output, clock, reset, advance, out_valid_ff)
   `XFWE_ASSERT_IMPLY(a_repeat_shape, clock, reset,
      out_valid_ff && out_result_ff.kind == xfwe_pkg::KIND_REPEAT,
      out_result_ff.header_len == xfwe_pkg::HDR_LEN_REPEAT && out_result_ff.payload_len == 7'd0)
   `XFWE_ASSERT_NEXT(a_new_window_stored, clock, reset,
      advance && result.kind == xfwe_pkg::KIND_NEW,
      !hist_ff.no_window && hist_ff.window_len == $past(result.payload_len))
   `XFWE_ASSERT_IMPLY(a_reuse_needs_window, clock, reset,
      out_valid_ff && out_result_ff.kind == xfwe_pkg::KIND_REUSE, !hist_ff.no_window)

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// XOR float window encoder testbench
// Drives sample bit patterns through the encoder with random bursts and
// output stalls, and checks every result against an in-bench encoder model
// or the typed result of its row. A short table of directed samples runs
// first and a few more at the end, with shaped random deltas in between.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1500;
   localparam int PLAN_ROWS = 24;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // Receiver stall patterns.
   typedef enum logic [1:0] {
      READY_ALWAYS   = 2'd0,
      READY_RANDOM   = 2'd1,
      READY_PERIODIC = 2'd2,
      READY_SPARSE   = 2'd3
   } ready_mode_type;

   // One directed row: the value is taken as is or XORed onto the last value sent.
   typedef struct packed {
      logic                 is_late;
      logic                 from_prev;
      logic                 typed;
      logic [63:0]          value;
      xfwe_pkg::result_type known;
   } plan_row_type;

   localparam xfwe_pkg::result_type NOT_TYPED = '0;
   localparam xfwe_pkg::result_type REPEAT_SEEN =
      '{xfwe_pkg::KIND_REPEAT, xfwe_pkg::HDR_REPEAT, xfwe_pkg::HDR_LEN_REPEAT, 64'd0, 7'd0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_value_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [12:0] rsp_header_bits;
   logic [3:0]  rsp_header_len;
   logic [63:0] rsp_payload;
   logic [6:0]  rsp_payload_len;

   xfwe_pkg::history_type history =
      '{awaiting_first: 1'b1, no_window: 1'b1, default: '0};
   xfwe_pkg::result_type  expected_results[$];
   int                    mismatches = 0;
   int                    burst_left = 0;
   ready_mode_type        ready_mode = READY_ALWAYS;
   int                    mode_left = 0;
   int                    ready_tick = 0;

   // Directed samples. Late rows run after the random part, because a full-width
   // window swallows every later difference and no new window can follow it.
   plan_row_type plan [PLAN_ROWS] = '{
      '{1'b0, 1'b0, 1'b1, ALL_ONES,
        '{xfwe_pkg::KIND_RAW, 13'd0, xfwe_pkg::HDR_LEN_RAW, ALL_ONES,
          xfwe_pkg::PAYLOAD_LEN_FULL}},
      '{1'b0, 1'b1, 1'b1, 64'd0, REPEAT_SEEN},
      '{1'b0, 1'b1, 1'b1, 64'd1,
        '{xfwe_pkg::KIND_NEW, {xfwe_pkg::HDR_NEW_CTL, xfwe_pkg::LEAD_CLAMP, 6'd33},
          xfwe_pkg::HDR_LEN_NEW, 64'd1, 7'd33}},
      '{1'b0, 1'b1, 1'b0, 64'h0000_0001_0000_0000, NOT_TYPED},
      '{1'b0, 1'b1, 1'b0, 64'h8000_0000_0000_0000, NOT_TYPED},
      '{1'b0, 1'b1, 1'b0, 64'h8000_0000_0000_0000, NOT_TYPED},
      '{1'b0, 1'b1, 1'b0, 64'h4000_0000_0000_0000, NOT_TYPED},
      '{1'b0, 1'b1, 1'b0, 64'h7FFF_FFFF_FFFF_FFFE, NOT_TYPED},
      '{1'b0, 1'b1, 1'b0, 64'h0000_0000_0000_8000, NOT_TYPED},
      '{1'b0, 1'b1, 1'b0, 64'h0000_0000_0000_0001, NOT_TYPED},
      '{1'b0, 1'b1, 1'b0, 64'h0000_0000_FFFF_FFFF, NOT_TYPED},
      '{1'b0, 1'b1, 1'b0, 64'h0000_0001_8000_0000, NOT_TYPED},
      '{1'b0, 1'b1, 1'b0, 64'h0000_0002_0000_0000, NOT_TYPED},
      '{1'b0, 1'b1, 1'b0, 64'hFFFF_FFFF_0000_0000, NOT_TYPED},
      '{1'b0, 1'b1, 1'b1, 64'd0, REPEAT_SEEN},
      '{1'b0, 1'b1, 1'b0, 64'h5555_5555_5555_5554, NOT_TYPED},
      '{1'b0, 1'b1, 1'b0, 64'h2AAA_AAAA_AAAA_AAA8, NOT_TYPED},
      '{1'b1, 1'b1, 1'b1, ALL_ONES,
        '{xfwe_pkg::KIND_NEW, {xfwe_pkg::HDR_NEW_CTL, 5'd0, 6'd0},
          xfwe_pkg::HDR_LEN_NEW, ALL_ONES, xfwe_pkg::PAYLOAD_LEN_FULL}},
      '{1'b1, 1'b1, 1'b1, 64'h8000_0000_0000_0001,
        '{xfwe_pkg::KIND_REUSE, xfwe_pkg::HDR_REUSE, xfwe_pkg::HDR_LEN_REUSE,
          64'h8000_0000_0000_0001, xfwe_pkg::PAYLOAD_LEN_FULL}},
      '{1'b1, 1'b1, 1'b1, 64'd1,
        '{xfwe_pkg::KIND_REUSE, xfwe_pkg::HDR_REUSE, xfwe_pkg::HDR_LEN_REUSE,
          64'd1, xfwe_pkg::PAYLOAD_LEN_FULL}},
      '{1'b1, 1'b0, 1'b0, 64'd0, NOT_TYPED},
      '{1'b1, 1'b0, 1'b1, 64'd0, REPEAT_SEEN},
      '{1'b1, 1'b0, 1'b1, ALL_ONES,
        '{xfwe_pkg::KIND_REUSE, xfwe_pkg::HDR_REUSE, xfwe_pkg::HDR_LEN_REUSE,
          ALL_ONES, xfwe_pkg::PAYLOAD_LEN_FULL}},
      '{1'b1, 1'b1, 1'b1, 64'd0, REPEAT_SEEN}
   };

   xor_float_window_encoder_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value_bits  (req_value_bits),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_header_bits (rsp_header_bits),
      .rsp_header_len  (rsp_header_len),
      .rsp_payload     (rsp_payload),
      .rsp_payload_len (rsp_payload_len)
   );

   always #10 clock = ~clock;

   // A mask of the n lowest bits, n up to 64.
   function automatic logic [63:0] ones_below(input int n);
      if (n >= xfwe_pkg::VALUE_BITS)
         return '1;
      return (64'd1 << n) - 64'd1;
   endfunction

   // A mask of bits hi down to lo.
   function automatic logic [63:0] bit_span(input int hi, input int lo);
      return ones_below(hi + 1) & ~ones_below(lo);
   endfunction

   // Encodes one value against the history and advances the history.
   function automatic xfwe_pkg::result_type encode_sample(input logic [63:0] value_in,
                                                          inout xfwe_pkg::history_type h);
      xfwe_pkg::result_type r;
      logic [63:0]          diff;
      int                   lead;
      int                   trail;
      int                   span;
      int                   shift;
      r = '0;
      if (h.awaiting_first) begin
         r = '{xfwe_pkg::KIND_RAW, 13'd0, xfwe_pkg::HDR_LEN_RAW, value_in,
               xfwe_pkg::PAYLOAD_LEN_FULL};
         h.previous_value = value_in;
         h.awaiting_first = 1'b0;
         return r;
      end
      diff = value_in ^ h.previous_value;
      if (diff == '0)
         return REPEAT_SEEN;
      lead = 0;
      while (diff[63 - lead] == 1'b0)
         lead++;
      trail = 0;
      while (diff[trail] == 1'b0)
         trail++;
      if (lead >= int'(xfwe_pkg::LEAD_LIMIT))
         lead = int'(xfwe_pkg::LEAD_CLAMP);
      span = xfwe_pkg::VALUE_BITS - lead - trail;
      // The difference fits the stored window, so only its bits are sent.
      if (!h.no_window && lead >= int'(h.window_lead) &&
          lead + span <= int'(h.window_lead) + int'(h.window_len)) begin
         shift = xfwe_pkg::VALUE_BITS - int'(h.window_lead) - int'(h.window_len);
         r.kind = xfwe_pkg::KIND_REUSE;
         r.header_bits = xfwe_pkg::HDR_REUSE;
         r.header_len = xfwe_pkg::HDR_LEN_REUSE;
         r.payload = (diff >> shift) & ones_below(int'(h.window_len));
         r.payload_len = h.window_len;
      end else begin
         // A length of 64 wraps to zero in the six-bit field.
         r.kind = xfwe_pkg::KIND_NEW;
         r.header_bits = {xfwe_pkg::HDR_NEW_CTL, lead[4:0], span[5:0]};
         r.header_len = xfwe_pkg::HDR_LEN_NEW;
         r.payload = (diff >> trail) & ones_below(span);
         r.payload_len = span[6:0];
         h.window_lead = lead[4:0];
         h.window_len = span[6:0];
         h.no_window = 1'b0;
      end
      h.previous_value = value_in;
      return r;
   endfunction

   // Predicts the result, then offers the value in bursts with random gaps.
   task automatic send_value(input logic [63:0] value_in, input logic typed,
                             input xfwe_pkg::result_type known);
      xfwe_pkg::result_type predicted;
      int                   gap;
      predicted = encode_sample(value_in, history);
      expected_results.push_back(typed ? known : predicted);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_value_bits <= value_in;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
   endtask

   // Sends the early or the late rows of the directed table.
   task automatic walk_plan(input logic late_part);
      logic [63:0] value_in;
      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (plan[i].is_late == late_part) begin
            value_in = plan[i].from_prev ? history.previous_value ^ plan[i].value
                                         : plan[i].value;
            send_value(value_in, plan[i].typed, plan[i].known);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // The receiver switches at random between stall patterns.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         ready_tick <= ready_tick + 1;
         case (ready_mode)
            READY_ALWAYS: begin
               rsp_ready <= 1'b1;
            end
            READY_RANDOM: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            READY_PERIODIC: begin
               rsp_ready <= (ready_tick % 4) != 3;
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 9) == 0);
            end
         endcase
      end
   end

   // Each result transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      xfwe_pkg::result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with nothing expected, kind %0d payload %0h",
                     $time, rsp_kind, rsp_payload);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("kind", 64'(want.kind), 64'(rsp_kind));
            check_field("header_bits", 64'(want.header_bits), 64'(rsp_header_bits));
            check_field("header_len", 64'(want.header_len), 64'(rsp_header_len));
            check_field("payload", want.payload, rsp_payload);
            check_field("payload_len", 64'(want.payload_len), 64'(rsp_payload_len));
         end
      end
   end

   // Stimulus: directed rows, shaped random deltas, then the full-width rows.
   initial begin
      logic [63:0] delta;
      int          pick;
      int          lead_pos;
      int          width;
      int          low_pos;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      walk_plan(1'b0);
      repeat (RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         delta = {$urandom, $urandom};
         if (pick < 12) begin
            delta = '0;
         end else if (pick < 50 && !history.no_window) begin
            // Random bits inside the stored window.
            delta &= bit_span(63 - int'(history.window_lead),
                              64 - int'(history.window_lead) - int'(history.window_len));
         end else if (pick < 85) begin
            // A difference with chosen leading and trailing edges.
            lead_pos = $urandom_range(0, 63);
            width = $urandom_range(1, 64 - lead_pos);
            low_pos = 64 - lead_pos - width;
            delta &= bit_span(63 - lead_pos, low_pos);
            delta[63 - lead_pos] = 1'b1;
            delta[low_pos] = 1'b1;
         end
         // Keep full-width windows out of the random part.
         if (delta[63] && delta[0])
            delta[$urandom_range(0, 1) * 63] = 1'b0;
         send_value(history.previous_value ^ delta, 1'b0, NOT_TYPED);
      end
      walk_plan(1'b1);
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #10_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

FILE: xor_float_window_encoder_top.f
+incdir+design
design/xfwe_pkg.sv
design/xfwe_zero_count.sv
design/xfwe_encode.sv
design/xor_float_window_encoder_top.sv
verif/testbench.sv
